/* src/aket_pkg.sv */
// ----------------------------------------------------------------------------
// aket_pkg
// Shared types and constants of the aging keyed entry table.
// ----------------------------------------------------------------------------
package aket_pkg;

	// Table geometry and field widths.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int PAY_W       = 64;
	localparam int STAMP_W     = 32;
	localparam int AGE_W       = 8;
	localparam int MODE_W      = 2;
	localparam int RIDX_W      = 5;

	localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(TABLE_DEPTH);
	localparam logic [AGE_W-1:0] MAX_AGE_RST = AGE_W'(5);

	// Item modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_UPDATE = 2'd0,
		MODE_EOF    = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AGE,
		ST_READ,
		ST_RESP
	} state_t;

	// One stored record.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/aket_if.sv */
// ----------------------------------------------------------------------------
// aket_if
// Valid/ready channels of the aging keyed entry table: input items, result
// items and the max_age configuration write.
// ----------------------------------------------------------------------------
interface aket_in_if;
	logic                          valid;
	logic                          ready;
	logic [aket_pkg::MODE_W-1:0]   mode;
	logic [aket_pkg::KEY_W-1:0]    record_key;
	logic [aket_pkg::PAY_W-1:0]    record_payload;
	logic [aket_pkg::RIDX_W-1:0]   read_index;

	modport source (output valid, mode, record_key, record_payload, read_index, input ready);
	modport sink   (input valid, mode, record_key, record_payload, read_index, output ready);
endinterface

interface aket_out_if;
	logic                          valid;
	logic                          ready;
	logic [aket_pkg::CNT_W-1:0]    entry_count;
	logic                          entry_valid;
	logic [aket_pkg::KEY_W-1:0]    entry_key;
	logic [aket_pkg::PAY_W-1:0]    entry_payload;
	logic                          insert_dropped;
	logic [aket_pkg::CNT_W-1:0]    removed_count;

	modport source (output valid, entry_count, entry_valid, entry_key, entry_payload,
		insert_dropped, removed_count, input ready);
	modport sink   (input valid, entry_count, entry_valid, entry_key, entry_payload,
		insert_dropped, removed_count, output ready);
endinterface

interface aket_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [aket_pkg::AGE_W-1:0]    max_age;

	modport source (output valid, max_age, input ready);
	modport sink   (input valid, max_age, output ready);
endinterface

/* src/aket_ram.sv */
// ----------------------------------------------------------------------------
// aket_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module aket_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/aging_keyed_entry_table.sv */
// ----------------------------------------------------------------------------
// aging_keyed_entry_table
// Ordered table of keyed records with frame-based aging, held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries one item: an update (look up the key, overwrite, append or drop when full),
//   an end of frame (remove aged entries, keep order, advance the frame
//   counter) or a read (entry at read_index plus the count). item_out returns
//   exactly one result item for every input item. cfg writes max_age at any
//   time the block is idle; its ready is always high.
// Work (one item at a time; all work goes through the single read port of
//   the entry RAM, one entry per cycle): an update scans the live entries in
//   order and stops at a hit; an end of frame checks every live entry; a read
//   reads the one entry; an unused mode goes straight to its result. The input
//   is ready again as soon as the result is loaded into the output register.
// Reset: live count and frame counter are cleared, max_age returns to 5. The
//   RAM is not cleared; only entries below the live count are ever used.
// Stall: a finished result waits in the output register while the next item
//   is accepted and worked on; a further result waits until that register
//   is taken.
// ----------------------------------------------------------------------------
module aging_keyed_entry_table (
	input  logic               clk,
	input  logic               arst_n,
	aket_in_if.sink            item_in,
	aket_out_if.source         item_out,
	aket_cfg_if.sink           cfg
);

	aket_pkg::state_t                 state_q, state_nx;
	logic [aket_pkg::CNT_W-1:0]       live_q;
	logic [aket_pkg::STAMP_W-1:0]     frame_q;
	logic [aket_pkg::AGE_W-1:0]       max_age_q;
	logic [aket_pkg::CNT_W-1:0]       rd_ptr_q;
	logic [aket_pkg::CNT_W-1:0]       w_q;
	logic                             chk_s1;
	logic [aket_pkg::IDX_W-1:0]       chk_idx_s1;
	logic [aket_pkg::KEY_W-1:0]       key_q;
	logic [aket_pkg::PAY_W-1:0]       pay_q;

	logic                             res_valid_q;
	logic [aket_pkg::KEY_W-1:0]       res_key_q;
	logic [aket_pkg::PAY_W-1:0]       res_pay_q;
	logic                             res_drop_q;
	logic [aket_pkg::CNT_W-1:0]       res_removed_q;

	logic                             out_valid_q;
	logic [aket_pkg::CNT_W-1:0]       out_count_q;
	logic                             out_evalid_q;
	logic [aket_pkg::KEY_W-1:0]       out_key_q;
	logic [aket_pkg::PAY_W-1:0]       out_pay_q;
	logic                             out_drop_q;
	logic [aket_pkg::CNT_W-1:0]       out_removed_q;

	logic                             mem_we;
	logic [aket_pkg::IDX_W-1:0]       mem_waddr;
	aket_pkg::entry_t                 mem_wdata;
	logic [aket_pkg::IDX_W-1:0]       mem_raddr;
	logic [aket_pkg::ENTRY_W-1:0]     mem_rdata;
	aket_pkg::entry_t                 rd_entry;

	logic                             accept;
	logic                             out_free;
	logic                             sweeping;
	logic                             issue;
	logic                             sweep_done;
	logic                             key_hit;
	logic [aket_pkg::STAMP_W-1:0]     age;
	logic                             keep;

	// Entry store.
	aket_ram #(
		.DEPTH (aket_pkg::TABLE_DEPTH),
		.WIDTH (aket_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Handshake and sweep control. Writes of one item land before the next
	// item reads, and during a compaction the write pointer trails the read
	// pointer, so no forwarding is needed. A key match only counts during
	// the update scan; the aging sweep must check every entry.
	assign item_in.ready = (state_q == aket_pkg::ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign accept        = item_in.valid && item_in.ready;
	assign out_free      = !out_valid_q || item_out.ready;
	assign sweeping      = (state_q == aket_pkg::ST_SCAN) || (state_q == aket_pkg::ST_AGE);
	assign issue         = sweeping && (rd_ptr_q < live_q);
	assign sweep_done    = !issue && !chk_s1;
	assign rd_entry      = aket_pkg::entry_t'(mem_rdata);
	assign key_hit       = chk_s1 && (state_q == aket_pkg::ST_SCAN) && (rd_entry.key == key_q);
	assign age           = frame_q - rd_entry.stamp;
	assign keep          = age < {{(aket_pkg::STAMP_W - aket_pkg::AGE_W){1'b0}}, max_age_q};
	assign mem_raddr     = (state_q == aket_pkg::ST_IDLE) ? item_in.read_index[aket_pkg::IDX_W-1:0]
	                                                     : rd_ptr_q[aket_pkg::IDX_W-1:0];

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			aket_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (aket_pkg::mode_t'(item_in.mode))
						aket_pkg::MODE_UPDATE: state_nx = aket_pkg::ST_SCAN;
						aket_pkg::MODE_EOF:    state_nx = aket_pkg::ST_AGE;
						aket_pkg::MODE_READ:   state_nx = aket_pkg::ST_READ;
						default:               state_nx = aket_pkg::ST_RESP;
					endcase
				end
			end
			aket_pkg::ST_SCAN: begin
				if (key_hit || sweep_done) begin
					state_nx = aket_pkg::ST_RESP;
				end
			end
			aket_pkg::ST_AGE: begin
				if (sweep_done) begin
					state_nx = aket_pkg::ST_RESP;
				end
			end
			aket_pkg::ST_READ: state_nx = aket_pkg::ST_RESP;
			aket_pkg::ST_RESP: begin
				if (out_free) begin
					state_nx = aket_pkg::ST_IDLE;
				end
			end
			default: state_nx = aket_pkg::ST_IDLE;
		endcase
	end

	// RAM write port: overwrite on hit, append on miss with room left, compaction on aging.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chk_idx_s1;
		mem_wdata = '{key: key_q, payload: pay_q, stamp: frame_q};
		unique case (state_q)
			aket_pkg::ST_SCAN: begin
				if (key_hit) begin
					mem_we = 1'b1;
				end else if (sweep_done && (live_q != aket_pkg::DEPTH_CNT)) begin
					mem_we    = 1'b1;
					mem_waddr = live_q[aket_pkg::IDX_W-1:0];
				end
			end
			aket_pkg::ST_AGE: begin
				if (chk_s1 && keep) begin
					mem_we    = 1'b1;
					mem_waddr = w_q[aket_pkg::IDX_W-1:0];
					mem_wdata = rd_entry;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aket_pkg::ST_IDLE;
			live_q      <= '0;
			frame_q     <= '0;
			max_age_q   <= aket_pkg::MAX_AGE_RST;
			rd_ptr_q    <= '0;
			w_q         <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg.valid && cfg.ready) begin
				max_age_q <= cfg.max_age;
			end
			if (accept) begin
				rd_ptr_q <= '0;
				w_q      <= '0;
				chk_s1   <= 1'b0;
			end else if (sweeping) begin
				chk_s1 <= issue && !key_hit;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			// Append on a miss with room left.
			if ((state_q == aket_pkg::ST_SCAN) && !key_hit && sweep_done
					&& (live_q != aket_pkg::DEPTH_CNT)) begin
				live_q <= live_q + 1'b1;
			end
			// Survivors advance the compaction pointer; the sweep end commits.
			if (state_q == aket_pkg::ST_AGE) begin
				if (chk_s1 && keep) begin
					w_q <= w_q + 1'b1;
				end
				if (sweep_done) begin
					live_q  <= w_q;
					frame_q <= frame_q + 1'b1;
				end
			end
			if ((state_q == aket_pkg::ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (item_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item fields, check stage and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q         <= item_in.record_key;
			pay_q         <= item_in.record_payload;
			res_valid_q   <= (aket_pkg::mode_t'(item_in.mode) == aket_pkg::MODE_READ)
				&& ({1'b0, item_in.read_index} < live_q);
			res_key_q     <= '0;
			res_pay_q     <= '0;
			res_drop_q    <= 1'b0;
			res_removed_q <= '0;
		end
		if (issue) begin
			chk_idx_s1 <= rd_ptr_q[aket_pkg::IDX_W-1:0];
		end
		if ((state_q == aket_pkg::ST_SCAN) && !key_hit && sweep_done
				&& (live_q == aket_pkg::DEPTH_CNT)) begin
			res_drop_q <= 1'b1;
		end
		if ((state_q == aket_pkg::ST_AGE) && sweep_done) begin
			res_removed_q <= live_q - w_q;
		end
		if ((state_q == aket_pkg::ST_READ) && res_valid_q) begin
			res_key_q <= rd_entry.key;
			res_pay_q <= rd_entry.payload;
		end
		if ((state_q == aket_pkg::ST_RESP) && out_free) begin
			out_count_q   <= live_q;
			out_evalid_q  <= res_valid_q;
			out_key_q     <= res_key_q;
			out_pay_q     <= res_pay_q;
			out_drop_q    <= res_drop_q;
			out_removed_q <= res_removed_q;
		end
	end

	// Result channel.
	assign item_out.valid          = out_valid_q;
	assign item_out.entry_count    = out_count_q;
	assign item_out.entry_valid    = out_evalid_q;
	assign item_out.entry_key      = out_key_q;
	assign item_out.entry_payload  = out_pay_q;
	assign item_out.insert_dropped = out_drop_q;
	assign item_out.removed_count  = out_removed_q;

`ifndef SYNTHESIS
	// The live count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= aket_pkg::DEPTH_CNT)
		else $error("live count above table depth");

	// Compaction writes never overtake the entry being checked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aket_pkg::ST_AGE) && mem_we |-> (w_q <= {1'b0, chk_idx_s1}))
		else $error("compaction write overtook read");

	// The end of a sweep advances the frame counter by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aket_pkg::ST_AGE) && sweep_done |=> (frame_q == $past(frame_q) + 1'b1))
		else $error("frame counter did not advance");

	// An append grows the table by exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aket_pkg::ST_SCAN) && !key_hit && sweep_done
			&& (live_q != aket_pkg::DEPTH_CNT) |=> (live_q == $past(live_q) + 1'b1))
		else $error("append did not grow the table");
`endif

endmodule
